// ===== hw/rtl/rfsh_pkg.sv =====
// Shared types, widths and codes for the read family size histogram block.
package rfsh_pkg;

  // Field widths
  localparam int REQ_W      = 1;
  localparam int MAPQ_W     = 8;
  localparam int FLAG_W     = 16;
  localparam int FAM_W      = 16;
  localparam int REV_W      = 16;
  localparam int BIDX_W     = 10;
  localparam int CNT_W      = 64;
  localparam int BIN_CNT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default histogram depth
  localparam int HIST_BINS_DEF = 1024;

  // Flag bits that reject a record
  localparam logic [FLAG_W-1:0] REJECT_MASK = 16'h0B00;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 1'b0,
    REQ_READ   = 1'b1
  } rfsh_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_MAPQ = 1'b0,
    CFG_MIN_FAM  = 1'b1
  } rfsh_cfg_idx_t;

  // Classification of one transaction, made by the front end
  typedef struct packed {
    logic is_rec;
    logic pass;
    logic multi;
  } rfsh_cls_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_records;
    logic [CNT_W-1:0] failed_records;
    logic [CNT_W-1:0] all_families;
    logic [CNT_W-1:0] all_size_sum;
    logic [CNT_W-1:0] all_reverse_sum;
    logic [CNT_W-1:0] multi_families;
    logic [CNT_W-1:0] multi_size_sum;
    logic [CNT_W-1:0] multi_reverse_sum;
  } rfsh_stats_t;

  typedef struct packed {
    logic                 accepted;
    rfsh_stats_t          stats;
    logic [BIN_CNT_W-1:0] bin_count;
  } rfsh_result_t;

endpackage

// ===== hw/rtl/rfsh_in_if.sv =====
// Input channel: one record or one bin read request per transaction.
interface rfsh_in_if;
  import rfsh_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [MAPQ_W-1:0] mapping_quality;
  logic [FLAG_W-1:0] read_flags;
  logic [FAM_W-1:0]  family_size;
  logic [REV_W-1:0]  reverse_count;
  logic [BIDX_W-1:0] bin_index;

  modport source (
    output valid, req_type, mapping_quality, read_flags, family_size, reverse_count,
           bin_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, mapping_quality, read_flags, family_size, reverse_count,
           bin_index,
    output ready
  );
endinterface

// ===== hw/rtl/rfsh_out_if.sv =====
// Result channel: counters and bin count after each transaction.
interface rfsh_out_if;
  import rfsh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [CNT_W-1:0]     total_records;
  logic [CNT_W-1:0]     failed_records;
  logic [CNT_W-1:0]     all_families;
  logic [CNT_W-1:0]     all_size_sum;
  logic [CNT_W-1:0]     all_reverse_sum;
  logic [CNT_W-1:0]     multi_families;
  logic [CNT_W-1:0]     multi_size_sum;
  logic [CNT_W-1:0]     multi_reverse_sum;
  logic [BIN_CNT_W-1:0] bin_count;

  modport source (
    output valid, accepted, total_records, failed_records, all_families, all_size_sum,
           all_reverse_sum, multi_families, multi_size_sum, multi_reverse_sum, bin_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, total_records, failed_records, all_families, all_size_sum,
           all_reverse_sum, multi_families, multi_size_sum, multi_reverse_sum, bin_count,
    output ready
  );
endinterface

// ===== hw/rtl/rfsh_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface rfsh_cfg_if;
  import rfsh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hw/rtl/rfsh_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module rfsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and read; a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/rfsh_queue.sv =====
// Small first-in first-out queue built from registers.
module rfsh_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// ===== hw/rtl/rfsh_front.sv =====
// Front end: accepts transactions, holds thresholds and classifies each record.
module rfsh_front #(
  parameter int HIST_BINS = rfsh_pkg::HIST_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rfsh_in_if.sink                       in_ch,
  rfsh_cfg_if.sink                      cfg_ch,
  input  logic                          clear_done,
  output logic                          item_valid,
  input  logic                          item_ready,
  output rfsh_pkg::rfsh_cls_t           item_cls,
  output logic [rfsh_pkg::FAM_W-1:0]    item_fam,
  output logic [rfsh_pkg::REV_W-1:0]    item_rev,
  output logic [$clog2(HIST_BINS)-1:0]  item_bin
);
  import rfsh_pkg::*;

  localparam int BIN_AW = $clog2(HIST_BINS);
  localparam logic [FAM_W:0] LAST_BIN = (FAM_W + 1)'(HIST_BINS - 1);

  logic [MAPQ_W-1:0] min_mapq_r;
  logic [FAM_W-1:0]  min_fam_r;
  logic [FAM_W:0]    bin_sel;
  logic              is_rec;

  // Take configuration writes at any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mapq_r <= '0;
      min_fam_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (rfsh_cfg_idx_t'(cfg_ch.index))
        CFG_MIN_MAPQ: min_mapq_r <= cfg_ch.data[MAPQ_W-1:0];
        CFG_MIN_FAM:  min_fam_r  <= cfg_ch.data[FAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off transactions until the histogram clear pass is over
  assign in_ch.ready = clear_done && item_ready;
  assign item_valid  = clear_done && in_ch.valid;

  // Classify the record
  assign is_rec = (rfsh_req_t'(in_ch.req_type) == REQ_RECORD);

  always_comb begin
    item_cls.is_rec = is_rec;
    item_cls.pass   = (in_ch.mapping_quality >= min_mapq_r) &&
                      (in_ch.family_size >= min_fam_r) &&
                      ((in_ch.read_flags & REJECT_MASK) == '0);
    item_cls.multi  = (in_ch.family_size > FAM_W'(1));
  end

  assign item_fam = in_ch.family_size;
  assign item_rev = in_ch.reverse_count;

  // Pick the bin and saturate into the last one
  assign bin_sel  = is_rec ? {1'b0, in_ch.family_size} : (FAM_W + 1)'(in_ch.bin_index);
  assign item_bin = (bin_sel >= LAST_BIN) ? LAST_BIN[BIN_AW-1:0] : bin_sel[BIN_AW-1:0];
endmodule

// ===== hw/rtl/rfsh_back.sv =====
// Back end: histogram read-modify-write with forwarding, counters, result buffer.
module rfsh_back #(
  parameter int HIST_BINS = rfsh_pkg::HIST_BINS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [$bits(rfsh_pkg::rfsh_cls_t) + rfsh_pkg::FAM_W + rfsh_pkg::REV_W
                + $clog2(HIST_BINS) - 1:0] item_data,
  output logic                    clear_done,
  rfsh_out_if.source              out_ch
);
  import rfsh_pkg::*;

  localparam int BIN_AW    = $clog2(HIST_BINS);
  localparam int OUT_DEPTH = 3;
  localparam int IW        = $clog2(OUT_DEPTH + 1);
  localparam int RES_W     = $bits(rfsh_result_t);

  rfsh_cls_t             q_cls;
  logic [FAM_W-1:0]      q_fam;
  logic [REV_W-1:0]      q_rev;
  logic [BIN_AW-1:0]     q_bin;

  logic                  clr_active_r;
  logic [BIN_AW-1:0]     clr_addr_r;

  logic [IW-1:0]         inflight_r, inflight_nxt;
  logic                  take;
  logic                  out_leave;

  logic                  a_valid_r;
  rfsh_cls_t             a_cls_r;
  logic [FAM_W-1:0]      a_fam_r;
  logic [REV_W-1:0]      a_rev_r;
  logic [BIN_AW-1:0]     a_bin_r;

  logic                  b_valid_r;
  rfsh_cls_t             b_cls_r;
  logic [FAM_W-1:0]      b_fam_r;
  logic [REV_W-1:0]      b_rev_r;
  logic [BIN_AW-1:0]     b_bin_r;

  logic                  ram_we;
  logic [BIN_AW-1:0]     ram_waddr;
  logic [BIN_CNT_W-1:0]  ram_wdata;
  logic [BIN_CNT_W-1:0]  ram_rdata;

  logic                  last_we_r;
  logic [BIN_AW-1:0]     last_addr_r;
  logic [BIN_CNT_W-1:0]  last_data_r;

  logic [BIN_CNT_W-1:0]  cur_count;
  logic [BIN_CNT_W-1:0]  new_count;
  logic                  bump;
  logic                  rec;
  logic                  multi;

  rfsh_stats_t           stats_r, stats_nxt;
  rfsh_result_t          res;
  rfsh_result_t          res_out;
  logic [RES_W-1:0]      res_out_bits;

  assign {q_cls, q_fam, q_rev, q_bin} = item_data;

  // Clear pass: walk every bin once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == BIN_AW'(HIST_BINS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign clear_done = !clr_active_r;

  // Pop only when the result buffer is sure to have room
  assign item_ready   = !clr_active_r && ((inflight_r != IW'(OUT_DEPTH)) || out_leave);
  assign take         = item_valid && item_ready;
  assign out_leave    = out_ch.valid && out_ch.ready;
  assign inflight_nxt = inflight_r + IW'(take) - IW'(out_leave);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      last_we_r  <= 1'b0;
      stats_r    <= '0;
    end else begin
      inflight_r <= inflight_nxt;
      a_valid_r  <= take;
      b_valid_r  <= a_valid_r;
      last_we_r  <= ram_we;
      stats_r    <= stats_nxt;
    end
  end

  // Stage payload: A issues the bin read, B updates
  always_ff @(posedge clk) begin
    if (take) begin
      a_cls_r <= q_cls;
      a_fam_r <= q_fam;
      a_rev_r <= q_rev;
      a_bin_r <= q_bin;
    end
    b_cls_r     <= a_cls_r;
    b_fam_r     <= a_fam_r;
    b_rev_r     <= a_rev_r;
    b_bin_r     <= a_bin_r;
    last_addr_r <= ram_waddr;
    last_data_r <= ram_wdata;
  end

  rfsh_ram #(
    .WIDTH (BIN_CNT_W),
    .DEPTH (HIST_BINS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (a_bin_r),
    .rd_data (ram_rdata)
  );

  // Forward the write that landed on the same edge as this bin's read
  assign cur_count = (last_we_r && (last_addr_r == b_bin_r)) ? last_data_r : ram_rdata;
  assign new_count = (cur_count != '1) ? cur_count + 1'b1 : cur_count;

  assign rec   = b_valid_r && b_cls_r.is_rec;
  assign bump  = rec && b_cls_r.pass;
  assign multi = bump && b_cls_r.multi;

  assign ram_we    = clr_active_r || bump;
  assign ram_waddr = clr_active_r ? clr_addr_r : b_bin_r;
  assign ram_wdata = clr_active_r ? '0 : new_count;

  // Update running counters
  always_comb begin
    stats_nxt = stats_r;
    if (rec) begin
      stats_nxt.total_records = stats_r.total_records + 1'b1;
    end
    if (rec && !b_cls_r.pass) begin
      stats_nxt.failed_records = stats_r.failed_records + 1'b1;
    end
    if (bump) begin
      stats_nxt.all_families    = stats_r.all_families + 1'b1;
      stats_nxt.all_size_sum    = stats_r.all_size_sum + CNT_W'(b_fam_r);
      stats_nxt.all_reverse_sum = stats_r.all_reverse_sum + CNT_W'(b_rev_r);
    end
    if (multi) begin
      stats_nxt.multi_families    = stats_r.multi_families + 1'b1;
      stats_nxt.multi_size_sum    = stats_r.multi_size_sum + CNT_W'(b_fam_r);
      stats_nxt.multi_reverse_sum = stats_r.multi_reverse_sum + CNT_W'(b_rev_r);
    end
  end

  // Build the result
  always_comb begin
    res.accepted  = bump;
    res.stats     = stats_nxt;
    res.bin_count = bump ? new_count : cur_count;
  end

  rfsh_queue #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (b_valid_r),
    .push_ready (),
    .push_data  (res),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (res_out_bits)
  );

  assign res_out = rfsh_result_t'(res_out_bits);

  // Drive the result channel
  assign out_ch.accepted          = res_out.accepted;
  assign out_ch.total_records     = res_out.stats.total_records;
  assign out_ch.failed_records    = res_out.stats.failed_records;
  assign out_ch.all_families      = res_out.stats.all_families;
  assign out_ch.all_size_sum      = res_out.stats.all_size_sum;
  assign out_ch.all_reverse_sum   = res_out.stats.all_reverse_sum;
  assign out_ch.multi_families    = res_out.stats.multi_families;
  assign out_ch.multi_size_sum    = res_out.stats.multi_size_sum;
  assign out_ch.multi_reverse_sum = res_out.stats.multi_reverse_sum;
  assign out_ch.bin_count         = res_out.bin_count;
endmodule

// ===== hw/rtl/read_family_size_histogram.sv =====
// Top level of the read family size histogram block.
//
// in_ch takes one transaction per record (req_type 0) or one bin read (req_type 1).
// out_ch returns exactly one result per input transaction, in order: the pass
// flag, the eight 64-bit counters after the transaction and the addressed bin.
// cfg_ch writes min_mapping_quality (index 0) and min_family_size (index 1);
// it is always ready and should be written only while the block is idle.
// Throughput: one transaction per cycle, sustained while out_ch.ready stays high. The histogram update is a
// two-stage read-modify-write on a single-port-write RAM, with forwarding of
// the write that coincides with the next read, so back-to-back hits on one bin
// do not stall.
// Path: an accepted input passes the item queue, stage A, stage B and the result buffer to out_ch.
// Reset: counters and thresholds clear at once; the histogram is then cleared
// one bin a cycle, every bin once, with in_ch.ready low the whole time.
// Stall: when out_ch.ready is low, a three-entry result buffer and a two-entry
// queue between front and back fill up, then in_ch.ready drops.
module read_family_size_histogram #(
  parameter int HIST_BINS = rfsh_pkg::HIST_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rfsh_in_if.sink     in_ch,
  rfsh_cfg_if.sink    cfg_ch,
  rfsh_out_if.source  out_ch
);
  import rfsh_pkg::*;

  localparam int BIN_AW = $clog2(HIST_BINS);
  localparam int ITEM_W = $bits(rfsh_cls_t) + FAM_W + REV_W + BIN_AW;

  logic              clear_done;
  logic              fe_valid;
  logic              fe_ready;
  rfsh_cls_t         fe_cls;
  logic [FAM_W-1:0]  fe_fam;
  logic [REV_W-1:0]  fe_rev;
  logic [BIN_AW-1:0] fe_bin;
  logic [ITEM_W-1:0] fe_item;
  logic              be_valid;
  logic              be_ready;
  logic [ITEM_W-1:0] be_item;

  rfsh_front #(
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .clear_done (clear_done),
    .item_valid (fe_valid),
    .item_ready (fe_ready),
    .item_cls   (fe_cls),
    .item_fam   (fe_fam),
    .item_rev   (fe_rev),
    .item_bin   (fe_bin)
  );

  assign fe_item = {fe_cls, fe_fam, fe_rev, fe_bin};

  // Decouple classification from the histogram update
  rfsh_queue #(
    .W     (ITEM_W),
    .DEPTH (2)
  ) u_item_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_item),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_data   (be_item)
  );

  rfsh_back #(
    .HIST_BINS (HIST_BINS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (be_valid),
    .item_ready (be_ready),
    .item_data  (be_item),
    .clear_done (clear_done),
    .out_ch     (out_ch)
  );
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the read family size histogram block.
module tb_top;
  import rfsh_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int NBINS        = HIST_BINS_DEF;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 200;
  localparam int JAM_CYCLES   = 64;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    rfsh_req_t         req;
    logic [MAPQ_W-1:0] mapq;
    logic [FLAG_W-1:0] flags;
    logic [FAM_W-1:0]  fam;
    logic [REV_W-1:0]  rev;
    logic [BIDX_W-1:0] bidx;
  } req_item_t;

  typedef struct {
    bit                    is_cfg;
    rfsh_cfg_idx_t         cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    req_item_t             item;
    bit                    typed;
    rfsh_result_t          exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rfsh_in_if  in_ch();
  rfsh_cfg_if cfg_ch();
  rfsh_out_if out_ch();

  read_family_size_histogram #(
    .HIST_BINS(NBINS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Predictor state: thresholds, counters and histogram
  logic [MAPQ_W-1:0]    thr_mapq;
  logic [FAM_W-1:0]     thr_fam;
  logic [CNT_W-1:0]     n_total, n_failed, n_all, all_size, all_rev;
  logic [CNT_W-1:0]     n_multi, multi_size, multi_rev;
  logic [BIN_CNT_W-1:0] fam_hist [0:NBINS-1];

  rfsh_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  int           mismatches;
  bit           calm;
  bit           jam_req;
  int unsigned  last_fam;

  // Typed expectation that rides along with the payload of a directed row
  bit           row_typed;
  rfsh_result_t row_exp;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    thr_mapq   = '0;
    thr_fam    = '0;
    n_total    = '0;
    n_failed   = '0;
    n_all      = '0;
    all_size   = '0;
    all_rev    = '0;
    n_multi    = '0;
    multi_size = '0;
    multi_rev  = '0;
    foreach (fam_hist[i]) fam_hist[i] = '0;
  end

  // Advance the predictor by one transaction and return the result it implies
  function automatic rfsh_result_t tally_item(req_item_t it);
    rfsh_result_t r;
    int unsigned  b;
    r = '0;
    if (it.req == REQ_RECORD) begin
      b = (it.fam >= NBINS - 1) ? NBINS - 1 : it.fam;
      n_total++;
      if (it.mapq < thr_mapq || it.fam < thr_fam || (it.flags & REJECT_MASK) != '0) begin
        n_failed++;
      end else begin
        r.accepted = 1'b1;
        if (it.fam > 1) begin
          n_multi++;
          multi_size += it.fam;
          multi_rev  += it.rev;
        end
        n_all++;
        all_size += it.fam;
        all_rev  += it.rev;
        // saturate the bin
        if (fam_hist[b] != '1) fam_hist[b]++;
      end
    end else begin
      b = (it.bidx >= NBINS - 1) ? NBINS - 1 : it.bidx;
    end
    r.stats.total_records     = n_total;
    r.stats.failed_records    = n_failed;
    r.stats.all_families      = n_all;
    r.stats.all_size_sum      = all_size;
    r.stats.all_reverse_sum   = all_rev;
    r.stats.multi_families    = n_multi;
    r.stats.multi_size_sum    = multi_size;
    r.stats.multi_reverse_sum = multi_rev;
    r.bin_count               = fam_hist[b];
    return r;
  endfunction

  function automatic rfsh_result_t mk_exp(logic acc, logic [63:0] tot, logic [63:0] fail,
                                          logic [63:0] af, logic [63:0] asz, logic [63:0] arv,
                                          logic [63:0] mf, logic [63:0] msz, logic [63:0] mrv,
                                          logic [31:0] bin);
    rfsh_result_t r;
    r.accepted                = acc;
    r.stats.total_records     = tot;
    r.stats.failed_records    = fail;
    r.stats.all_families      = af;
    r.stats.all_size_sum      = asz;
    r.stats.all_reverse_sum   = arv;
    r.stats.multi_families    = mf;
    r.stats.multi_size_sum    = msz;
    r.stats.multi_reverse_sum = mrv;
    r.bin_count               = bin;
    return r;
  endfunction

  function automatic req_item_t rec_item(int unsigned mapq, int unsigned flags,
                                         int unsigned fam, int unsigned rev);
    req_item_t it;
    it.req   = REQ_RECORD;
    it.mapq  = MAPQ_W'(mapq);
    it.flags = FLAG_W'(flags);
    it.fam   = FAM_W'(fam);
    it.rev   = REV_W'(rev);
    it.bidx  = '0;
    return it;
  endfunction

  function automatic req_item_t bin_read(int unsigned bidx);
    req_item_t it;
    it       = rec_item(0, 0, 0, 0);
    it.req   = REQ_READ;
    it.bidx  = BIDX_W'(bidx);
    return it;
  endfunction

  function automatic void add_row(req_item_t it, bit typed, rfsh_result_t exp);
    dir_row_t row;
    row.is_cfg   = 1'b0;
    row.cfg_idx  = CFG_MIN_MAPQ;
    row.cfg_data = '0;
    row.item     = it;
    row.typed    = typed;
    row.exp      = exp;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(rfsh_cfg_idx_t idx, int unsigned data);
    dir_row_t row;
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = CFG_DATA_W'(data);
    row.item     = rec_item(0, 0, 0, 0);
    row.typed    = 1'b0;
    row.exp      = '0;
    dir_rows.push_back(row);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random transaction: mostly records that clear the filters, some noise and bin reads
  function automatic req_item_t gen_item(int unsigned mq_min, int unsigned fam_min);
    req_item_t   it;
    int unsigned pick;
    it.req   = REQ_RECORD;
    it.mapq  = MAPQ_W'($urandom_range(0, 255));
    it.flags = FLAG_W'($urandom_range(0, 65535));
    it.fam   = '0;
    it.rev   = REV_W'($urandom_range(0, 65535));
    it.bidx  = BIDX_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.req = REQ_READ;
      if ($urandom_range(0, 1) != 0) it.bidx = BIDX_W'($urandom_range(0, 15));
    end else begin
      // repeat the last size often to hit the same bin back to back
      pick = $urandom_range(0, 99);
      if (pick < 40) it.fam = FAM_W'(last_fam);
      else if (pick < 75) it.fam = FAM_W'($urandom_range(0, 8));
      else if (pick < 85) it.fam = FAM_W'($urandom_range(NBINS - 6, NBINS + 6));
      else it.fam = FAM_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 85) begin
        it.mapq  = MAPQ_W'($urandom_range(mq_min, 255));
        it.flags = it.flags & ~REJECT_MASK;
        if (it.fam < fam_min) it.fam = FAM_W'($urandom_range(fam_min, 65535));
      end
      last_fam = it.fam;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one transaction, optionally after a gap, and hold until accepted
  task automatic send_item(req_item_t it, bit typed, rfsh_result_t exp);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.req_type        <= it.req;
    in_ch.mapping_quality <= it.mapq;
    in_ch.read_flags      <= it.flags;
    in_ch.family_size     <= it.fam;
    in_ch.reverse_count   <= it.rev;
    in_ch.bin_index       <= it.bidx;
    row_typed             <= typed;
    row_exp               <= exp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then drop valid
  task automatic write_cfg(rfsh_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Track accepted transactions and queue their expected results
  always @(posedge clk) begin : in_mon
    req_item_t    cur;
    rfsh_result_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cur.req   = rfsh_req_t'(in_ch.req_type);
      cur.mapq  = in_ch.mapping_quality;
      cur.flags = in_ch.read_flags;
      cur.fam   = in_ch.family_size;
      cur.rev   = in_ch.reverse_count;
      cur.bidx  = in_ch.bin_index;
      want = tally_item(cur);
      pending_results.push_back(row_typed ? row_exp : want);
    end
  end

  // Mirror register writes into the predictor
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (rfsh_cfg_idx_t'(cfg_ch.index))
        CFG_MIN_MAPQ: thr_mapq = cfg_ch.data[MAPQ_W-1:0];
        CFG_MIN_FAM:  thr_fam  = cfg_ch.data[FAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : out_mon
    rfsh_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, total_records", out_ch.total_records, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", out_ch.accepted, want.accepted);
        check_field("total_records", out_ch.total_records, want.stats.total_records);
        check_field("failed_records", out_ch.failed_records, want.stats.failed_records);
        check_field("all_families", out_ch.all_families, want.stats.all_families);
        check_field("all_size_sum", out_ch.all_size_sum, want.stats.all_size_sum);
        check_field("all_reverse_sum", out_ch.all_reverse_sum, want.stats.all_reverse_sum);
        check_field("multi_families", out_ch.multi_families, want.stats.multi_families);
        check_field("multi_size_sum", out_ch.multi_size_sum, want.stats.multi_size_sum);
        check_field("multi_reverse_sum", out_ch.multi_reverse_sum,
                    want.stats.multi_reverse_sum);
        check_field("bin_count", out_ch.bin_count, want.bin_count);
      end
    end
  end

  // Result side: random stalls, and one long hold-off to back the block up
  initial begin : result_sink
    int  hold;
    bit  jam_done;
    hold     = 0;
    jam_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (jam_req && !jam_done) begin
        jam_done = 1'b1;
        hold     = JAM_CYCLES;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (calm || $urandom_range(0, 99) >= 20) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        hold = pick_gap() - 1;
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("read_family_size_histogram regression: fail");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases
  initial begin
    int unsigned mq_data;
    int unsigned fam_min;
    mismatches = 0;
    calm       = 1'b0;
    jam_req    = 1'b0;
    last_fam   = 0;
    row_typed  = 1'b0;
    row_exp    = '0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.req_type        <= REQ_RECORD;
    in_ch.mapping_quality <= '0;
    in_ch.read_flags      <= '0;
    in_ch.family_size     <= '0;
    in_ch.reverse_count   <= '0;
    in_ch.bin_index       <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_MIN_MAPQ;
    cfg_ch.data           <= '0;

    // Directed rows: empty histogram, extremes, each reject bit, same-bin bursts
    add_row(bin_read(0), 1'b1, mk_exp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(bin_read(NBINS - 1), 1'b1, mk_exp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(rec_item(0, 0, 0, 0), 1'b1, mk_exp(1, 1, 0, 1, 0, 0, 0, 0, 0, 1));
    add_row(rec_item(255, 0, 1, 65535), 1'b1, mk_exp(1, 2, 0, 2, 1, 65535, 0, 0, 0, 1));
    add_row(rec_item(255, 16'hF4FF, 65535, 65535), 1'b1,
            mk_exp(1, 3, 0, 3, 65536, 131070, 1, 65535, 65535, 1));
    add_row(rec_item(7, 0, NBINS - 1, 7), 1'b0, '0);
    add_row(rec_item(9, 0, NBINS - 2, 0), 1'b0, '0);
    add_row(rec_item(200, 16'h0100, 5, 3), 1'b0, '0);
    add_row(rec_item(200, 16'h0200, 5, 3), 1'b0, '0);
    add_row(rec_item(200, 16'h0800, 5, 3), 1'b0, '0);
    add_row(rec_item(200, 16'hFFFF, 5, 3), 1'b0, '0);
    add_row(bin_read(NBINS - 1), 1'b0, '0);
    add_row(bin_read(0), 1'b0, '0);
    add_row(rec_item(30, 0, 2, 1), 1'b0, '0);
    add_row(rec_item(31, 0, 2, 2), 1'b0, '0);
    add_row(rec_item(32, 0, 2, 0), 1'b0, '0);
    add_cfg(CFG_MIN_MAPQ, 255);
    add_cfg(CFG_MIN_FAM, 65535);
    add_row(rec_item(254, 0, 65535, 4), 1'b0, '0);
    add_row(rec_item(255, 0, 65534, 4), 1'b0, '0);
    add_row(rec_item(255, 0, 65535, 4), 1'b0, '0);
    add_row(bin_read(NBINS - 1), 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_cfg(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random phases, each under its own thresholds
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph == 1 || ph == 4);
      if (ph == 5) begin
        mq_data = $urandom_range(0, 65535);
        fam_min = $urandom_range(0, 65535);
      end else begin
        mq_data = $urandom_range(0, 40);
        fam_min = (ph == 2) ? $urandom_range(2, 6) : $urandom_range(0, 2);
      end
      write_cfg(CFG_MIN_MAPQ, CFG_DATA_W'(mq_data));
      write_cfg(CFG_MIN_FAM, CFG_DATA_W'(fam_min));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 20) jam_req <= 1'b1;
        send_item(gen_item(mq_data & 8'hFF, fam_min), 1'b0, '0);
      end
    end

    // Drain and finish
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("read_family_size_histogram regression: pass");
    end else begin
      $display("read_family_size_histogram regression: fail");
    end
    $finish;
  end

endmodule
